>>> sv/sacd_pkg.sv
// Shared constants and controller/datapath types for the cache tag directory.
`timescale 1ns / 1ps
`default_nettype none

package sacd_pkg;

	localparam int DEF_WAYS       = 16;
	localparam int DEF_SETS       = 4096;
	localparam int DEF_LINE_BYTES = 64;

	localparam int ADDR_W   = 32;
	localparam int BYTE_W   = 8;
	localparam int RWAY_W   = 4;
	localparam int WAYOUT_W = 4;
	localparam int COST_W   = 64;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 144;

	localparam logic       MODE_READ  = 1'b0;
	localparam logic       MODE_WRITE = 1'b1;
	localparam logic [7:0] COST_HIT   = 8'd2;
	localparam logic [7:0] COST_MISS  = 8'd200;

	typedef struct packed {
		logic clear_wr;
		logic capture;
		logic lookup;
		logic load_out;
	} sacd_cmd_t;

	typedef struct packed {
		logic clear_last;
	} sacd_sts_t;

endpackage

`default_nettype wire

>>> sv/sacd_ctrl.sv
// Controller state machine: clearing pass, accept, lookup and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module sacd_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	input  sacd_pkg::sacd_sts_t sts,
	output sacd_pkg::sacd_cmd_t cmd
);
	import sacd_pkg::*;

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_LOOK  = 2'd2;
	localparam logic [1:0] ST_PUSH  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;

	always_comb begin
		s_tready     = (state_q == ST_IDLE);
		cmd.clear_wr = (state_q == ST_CLEAR);
		cmd.capture  = s_tready && s_tvalid;
		cmd.lookup   = (state_q == ST_LOOK);
		cmd.load_out = (state_q == ST_PUSH) && (!out_valid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd.capture) state_d = ST_LOOK;
			end
			ST_LOOK: begin
				state_d = ST_PUSH;
			end
			ST_PUSH: begin
				if (cmd.load_out) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

`default_nettype wire

>>> sv/sacd_dpath.sv
// Datapath: set memories, tag compare, victim choice, cost counter, result register.
`timescale 1ns / 1ps
`default_nettype none

module sacd_dpath #(
	parameter int WAYS       = sacd_pkg::DEF_WAYS,
	parameter int SETS       = sacd_pkg::DEF_SETS,
	parameter int LINE_BYTES = sacd_pkg::DEF_LINE_BYTES
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  sacd_pkg::sacd_cmd_t                  cmd,
	output sacd_pkg::sacd_sts_t                  sts,
	input  wire                                  in_mode,
	input  wire [sacd_pkg::ADDR_W-1:0]           in_addr,
	input  wire [sacd_pkg::BYTE_W-1:0]           in_write_data,
	input  wire [sacd_pkg::RWAY_W-1:0]           in_random_way,
	output logic [sacd_pkg::M_TDATA_W-1:0]       out_data
);
	import sacd_pkg::*;

	// SETS and LINE_BYTES are powers of two
	localparam int OFF_W  = $clog2(LINE_BYTES);
	localparam int IDX_W  = $clog2(SETS);
	localparam int SET_AW = (IDX_W > 0) ? IDX_W : 1;
	localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
	localparam int WAY_W  = $clog2(WAYS);

	typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

	// set memories: one row per set
	tag_row_t        tag_mem [SETS];
	logic [WAYS-1:0] vld_mem [SETS];
	logic [WAYS-1:0] dty_mem [SETS];

	tag_row_t        tag_rd_q;
	logic [WAYS-1:0] vld_rd_q;
	logic [WAYS-1:0] dty_rd_q;

	logic [SET_AW-1:0] clr_cnt_q;
	logic [COST_W-1:0] cost_q;

	logic              mode_q;
	logic [ADDR_W-1:0] addr_q;
	logic [BYTE_W-1:0] wdata_q;
	logic [WAY_W-1:0]  rway_q;
	logic [TAG_W-1:0]  tag_q;
	logic [SET_AW-1:0] set_q;

	logic [SET_AW-1:0] set_in;
	logic [SET_AW-1:0] wr_set;

	logic [WAYS-1:0]   match;
	logic              hit;
	logic              full;
	logic [WAY_W-1:0]  hit_way;
	logic [WAY_W-1:0]  inv_way;
	logic [WAY_W-1:0]  use_way;
	logic [WAYS-1:0]   way_oh;
	logic              wb;
	logic [ADDR_W-1:0] wb_addr;
	logic [ADDR_W-1:0] fill_addr;
	logic              wt;
	logic [COST_W-1:0] cost_d;

	tag_row_t          tag_wr;
	logic [WAYS-1:0]   vld_wr;
	logic [WAYS-1:0]   dty_wr;

	logic [M_TDATA_W-1:0] res_q;
	logic [M_TDATA_W-1:0] res_d;

	function automatic logic [WAY_W-1:0] way_mod(input logic [RWAY_W-1:0] rw);
		logic [RWAY_W:0] r;
		r = {1'b0, rw};
		for (int i = 0; i < 8; i++) begin
			if (r >= (RWAY_W+1)'(WAYS)) r = r - (RWAY_W+1)'(WAYS);
		end
		return WAY_W'(r);
	endfunction

	assign set_in = SET_AW'((in_addr >> OFF_W) & ADDR_W'(SETS - 1));
	assign wr_set = cmd.clear_wr ? clr_cnt_q : set_q;

	assign sts.clear_last = (clr_cnt_q == SET_AW'(SETS - 1));

	// clearing pass counter and cost counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			cost_q    <= '0;
		end else begin
			if (cmd.clear_wr) clr_cnt_q <= clr_cnt_q + SET_AW'(1);
			if (cmd.lookup) cost_q <= cost_d;
		end
	end

	// capture the beat and start the set read
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q   <= in_mode;
			addr_q   <= in_addr;
			wdata_q  <= in_write_data;
			rway_q   <= way_mod(in_random_way);
			tag_q    <= TAG_W'(in_addr >> (OFF_W + IDX_W));
			set_q    <= set_in;
			tag_rd_q <= tag_mem[set_in];
			vld_rd_q <= vld_mem[set_in];
			dty_rd_q <= dty_mem[set_in];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) tag_mem[set_q] <= tag_wr;
		if (cmd.lookup || cmd.clear_wr) begin
			vld_mem[wr_set] <= vld_wr;
			dty_mem[wr_set] <= dty_wr;
		end
	end

	always_comb begin
		hit_way = '0;
		inv_way = '0;
		for (int w = 0; w < WAYS; w++) begin
			match[w] = vld_rd_q[w] && (tag_rd_q[w] == tag_q);
		end
		// lowest matching way wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) hit_way = WAY_W'(w);
		end
		// highest invalid way wins
		for (int w = 0; w < WAYS; w++) begin
			if (!vld_rd_q[w]) inv_way = WAY_W'(w);
		end
		hit     = |match;
		full    = &vld_rd_q;
		use_way = hit ? hit_way : (full ? rway_q : inv_way);
		way_oh  = WAYS'(1) << use_way;

		wb      = !hit && full && dty_rd_q[use_way];
		wb_addr = wb ? ((ADDR_W'(tag_rd_q[use_way]) << IDX_W) | ADDR_W'(set_q)) << OFF_W
		             : '0;
		fill_addr = hit ? '0 : (addr_q >> OFF_W) << OFF_W;
		wt      = !hit && (mode_q == MODE_WRITE);

		cost_d = cost_q;
		if (mode_q == MODE_READ) begin
			cost_d = cost_q + COST_W'(hit ? COST_HIT : COST_MISS);
		end

		tag_wr = tag_rd_q;
		vld_wr = vld_rd_q;
		dty_wr = dty_rd_q;
		if (cmd.clear_wr) begin
			vld_wr = '0;
			dty_wr = '0;
		end else if (hit) begin
			if (mode_q == MODE_WRITE) dty_wr = dty_rd_q | way_oh;
		end else begin
			tag_wr[use_way] = tag_q;
			vld_wr          = vld_rd_q | way_oh;
			dty_wr          = dty_rd_q & ~way_oh;
		end

		res_d = {cost_d, (wt ? wdata_q : BYTE_W'(0)), wt, fill_addr, !hit,
		         wb_addr, wb, WAYOUT_W'(use_way), hit};
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) res_q <= res_d;
		if (cmd.load_out) out_data <= res_q;
	end

endmodule

`default_nettype wire

>>> sv/set_assoc_cache_directory.sv
// Top level of the set-associative write-back cache tag directory.
// Each beat goes through set read, compare and row write, and result load, in that order;
// the result loads once the output register is free, and only then is a new beat taken.
// The next beat is taken while an earlier result still waits on the master side.
// Reset clears the cost counter, then a clearing pass zeroes the valid and dirty rows
// one set per cycle; no beat is taken during that pass.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_directory #(
	parameter int WAYS       = sacd_pkg::DEF_WAYS,
	parameter int SETS       = sacd_pkg::DEF_SETS,
	parameter int LINE_BYTES = sacd_pkg::DEF_LINE_BYTES
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// addr[31:0], write_data[39:32], random_way[43:40], zero pad[47:44]
	input  wire [sacd_pkg::S_TDATA_W-1:0]     s_tdata,
	// mode
	input  wire                               s_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	// hit[0], way[4:1], writeback[5], writeback_addr[37:6], fill[38],
	// fill_addr[70:39], write_through[71], write_through_data[79:72], cost_total[143:80]
	output logic [sacd_pkg::M_TDATA_W-1:0]    m_tdata
);
	import sacd_pkg::*;

	sacd_cmd_t cmd;
	sacd_sts_t sts;

	sacd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sacd_dpath #(
		.WAYS       (WAYS),
		.SETS       (SETS),
		.LINE_BYTES (LINE_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_mode       (s_tuser),
		.in_addr       (s_tdata[31:0]),
		.in_write_data (s_tdata[39:32]),
		.in_random_way (s_tdata[43:40]),
		.out_data      (m_tdata)
	);

endmodule

`default_nettype wire

>>> sv/sacd_checker.sv
// Port-level checks for the cache tag directory, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sacd_checker (
	input wire                           clk,
	input wire                           arst_n,
	input wire                           s_tvalid,
	input wire                           s_tready,
	input wire                           m_tvalid,
	input wire                           m_tready,
	input wire [sacd_pkg::M_TDATA_W-1:0] m_tdata
);
	import sacd_pkg::*;

	// one access in flight: input side closes after a beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an access is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_hit_no_miss_actions: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> !m_tdata[38] && !m_tdata[5] && !m_tdata[71])
		else $error("hit beat carries miss actions");

	a_fill_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[38])
		else $error("miss beat without fill");

	a_no_wb_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[5] |-> m_tdata[37:6] == 32'd0)
		else $error("writeback address without writeback");

endmodule

bind set_assoc_cache_directory sacd_checker u_sacd_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/sv/set_assoc_cache_directory_tb.sv
// Self-checking testbench for the set-associative cache tag directory.
`timescale 1ns / 1ps

module set_assoc_cache_directory_tb;
	import sacd_pkg::*;

	localparam int WAYS_N      = DEF_WAYS;
	localparam int SETS_N      = DEF_SETS;
	localparam int OFF_W       = $clog2(DEF_LINE_BYTES);
	localparam int SET_W       = $clog2(DEF_SETS);
	localparam int TAG_W       = ADDR_W - OFF_W - SET_W;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] wdata;
		logic [RWAY_W-1:0] rway;
	} access_t;

	// same layout as m_tdata, highest field first
	typedef struct packed {
		logic [COST_W-1:0]   cost;
		logic [BYTE_W-1:0]   wt_data;
		logic                wt;
		logic [ADDR_W-1:0]   fill_addr;
		logic                fill;
		logic [ADDR_W-1:0]   wb_addr;
		logic                wb;
		logic [WAYOUT_W-1:0] way;
		logic                hit;
	} lookup_t;

	typedef enum int { RX_ALWAYS, RX_RANDOM, RX_PATTERN } rx_style_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic                 s_tuser  = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;

	// directory copy kept by the predictor
	logic [TAG_W-1:0]  line_tag   [SETS_N*WAYS_N];
	bit                line_valid [SETS_N*WAYS_N];
	bit                line_dirty [SETS_N*WAYS_N];
	logic [COST_W-1:0] cost_run = '0;

	lookup_t pending_lookups[$];
	int      error_count   = 0;
	int      cycle_count   = 0;
	int      tx_gap_max    = 0;
	int      burst_left    = 1;
	int      hold_request  = 0;
	int      hold_left     = 0;
	int      rx_phase      = 0;
	rx_style_t rx_style    = RX_ALWAYS;

	logic [SET_W-1:0] set_pool [6];
	logic [TAG_W-1:0] tag_pool [24];

	set_assoc_cache_directory i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("set_assoc_cache_directory: mismatch");
			$finish;
		end
	end

	function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tag,
			logic [SET_W-1:0] set_idx, logic [OFF_W-1:0] offset);
		return {tag, set_idx, offset};
	endfunction

	// Look up one access in the directory copy and update it.
	function automatic lookup_t predict_lookup(access_t acc);
		lookup_t          r;
		logic [SET_W-1:0] set_idx;
		logic [TAG_W-1:0] tag;
		int               base;
		bit               found;
		r       = '0;
		set_idx = acc.addr[OFF_W +: SET_W];
		tag     = acc.addr[ADDR_W-1 -: TAG_W];
		base    = set_idx * WAYS_N;
		found   = 1'b0;
		// lowest matching way wins
		for (int w = 0; w < WAYS_N; w++) begin
			if (!found && line_valid[base+w] && line_tag[base+w] == tag) begin
				found = 1'b1;
				r.way = WAYOUT_W'(w);
			end
		end
		r.hit = found;
		if (found) begin
			if (acc.mode == MODE_WRITE)
				line_dirty[base+r.way] = 1'b1;
			else
				cost_run += COST_HIT;
		end else begin
			// highest invalid way, else the supplied random way
			for (int w = 0; w < WAYS_N; w++) begin
				if (!line_valid[base+w]) begin
					r.way = WAYOUT_W'(w);
					found = 1'b1;
				end
			end
			if (!found) begin
				r.way = WAYOUT_W'(acc.rway % WAYS_N);
				if (line_dirty[base+r.way]) begin
					r.wb      = 1'b1;
					r.wb_addr = line_addr(line_tag[base+r.way], set_idx, '0);
				end
			end
			if (acc.mode == MODE_WRITE) begin
				r.wt      = 1'b1;
				r.wt_data = acc.wdata;
			end else begin
				cost_run += COST_MISS;
			end
			r.fill      = 1'b1;
			r.fill_addr = {acc.addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
			line_tag[base+r.way]   = tag;
			line_valid[base+r.way] = 1'b1;
			line_dirty[base+r.way] = 1'b0;
		end
		r.cost = cost_run;
		return r;
	endfunction

	// Offer one beat and wait until it is taken; gaps fall between bursts.
	task automatic send_access(input logic mode, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] wdata, input logic [RWAY_W-1:0] rway);
		access_t acc;
		int      gap;
		acc = '{mode: mode, addr: addr, wdata: wdata, rway: rway};
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {{(S_TDATA_W-ADDR_W-BYTE_W-RWAY_W){1'b0}}, rway, wdata, addr};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_lookups.push_back(predict_lookup(acc));
		if (tx_gap_max > 0) begin
			burst_left--;
			if (burst_left <= 0) begin
				gap = $urandom_range(1, tx_gap_max);
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1)
					@(negedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic send_random_access();
		logic [ADDR_W-1:0] addr;
		// mostly a few hot sets with a small tag pool, so sets fill and evict
		if ($urandom_range(0, 99) < 80)
			addr = line_addr(tag_pool[$urandom_range(0, 23)], set_pool[$urandom_range(0, 5)],
				OFF_W'($urandom_range(0, (1 << OFF_W) - 1)));
		else
			addr = $urandom;
		send_access(($urandom_range(0, 99) < 40) ? MODE_WRITE : MODE_READ, addr,
			BYTE_W'($urandom_range(0, 255)), RWAY_W'($urandom_range(0, 15)));
	endtask

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_style)
				RX_ALWAYS: m_tready <= 1'b1;
				RX_RANDOM: m_tready <= ($urandom_range(0, 3) != 0);
				default: begin
					m_tready <= ((rx_phase % 7) < 4);
					rx_phase++;
				end
			endcase
		end
	end

	task automatic check_field(input string name, input logic [COST_W-1:0] want,
			input logic [COST_W-1:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		lookup_t want;
		lookup_t got;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got = m_tdata;
			if (pending_lookups.size() == 0) begin
				error_count++;
				$display("%0t ns: unexpected beat expected none actual %0h", $time, m_tdata);
			end else begin
				want = pending_lookups.pop_front();
				check_field("hit", want.hit, got.hit);
				check_field("way", want.way, got.way);
				check_field("writeback", want.wb, got.wb);
				check_field("writeback_addr", want.wb_addr, got.wb_addr);
				check_field("fill", want.fill, got.fill);
				check_field("fill_addr", want.fill_addr, got.fill_addr);
				check_field("write_through", want.wt, got.wt);
				check_field("write_through_data", want.wt_data, got.wt_data);
				check_field("cost_total", want.cost, got.cost);
			end
		end
	end

	task automatic test_directed();
		rx_style   = RX_ALWAYS;
		tx_gap_max = 0;
		send_access(MODE_READ, line_addr(0, 0, 0), 8'h00, 4'h0);
		send_access(MODE_READ, line_addr(0, 0, 63), 8'h00, 4'h0);
		send_access(MODE_WRITE, line_addr(0, 0, 5), 8'hA5, 4'h0);
		send_access(MODE_WRITE, 32'hFFFF_FFFF, 8'hFF, 4'hF);
		send_access(MODE_READ, 32'hFFFF_FFC0, 8'h00, 4'hF);
		// fill set 0 to all ways
		for (int t = 1; t < WAYS_N; t++)
			send_access(MODE_READ, line_addr(TAG_W'(t), '0, OFF_W'(t)), 8'h00, RWAY_W'(t));
		// full set: dirty victim gives a writeback
		send_access(MODE_READ, line_addr(16, 0, 0), 8'h00, 4'hF);
		// full set, clean victim, write miss goes to memory
		send_access(MODE_WRITE, line_addr(17, 0, 1), 8'h00, 4'h0);
		send_access(MODE_WRITE, line_addr(17, 0, 2), 8'h5A, 4'h3);
		send_access(MODE_READ, line_addr(18, 0, 3), 8'h00, 4'h0);
	endtask

	task automatic test_hot_set_traffic(input int n);
		rx_style   = RX_RANDOM;
		tx_gap_max = 6;
		repeat (n)
			send_random_access();
	endtask

	task automatic test_back_to_back(input int n);
		rx_style   = RX_ALWAYS;
		tx_gap_max = 0;
		repeat (n)
			send_random_access();
	endtask

	task automatic test_output_hold(input int n);
		rx_style     = RX_ALWAYS;
		tx_gap_max   = 0;
		hold_request = 300;
		repeat (n)
			send_random_access();
	endtask

	task automatic test_periodic_stall(input int n);
		rx_style   = RX_PATTERN;
		tx_gap_max = 4;
		repeat (n)
			send_random_access();
	endtask

	initial begin
		set_pool[0] = '0;
		set_pool[1] = '1;
		for (int i = 2; i < 6; i++)
			set_pool[i] = SET_W'($urandom);
		tag_pool[0] = '0;
		tag_pool[1] = '1;
		for (int i = 2; i < 24; i++)
			tag_pool[i] = TAG_W'($urandom);

		repeat (4)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_hot_set_traffic(400);
		test_back_to_back(150);
		test_output_hold(60);
		test_periodic_stall(220);

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_lookups.size() != 0)
			@(posedge clk);
		repeat (10)
			@(posedge clk);

		if (error_count == 0)
			$display("set_assoc_cache_directory: match");
		else
			$display("set_assoc_cache_directory: mismatch");
		$finish;
	end

endmodule

>>> sim.f
sv/sacd_pkg.sv
sv/sacd_ctrl.sv
sv/sacd_dpath.sv
sv/set_assoc_cache_directory.sv
sv/sacd_checker.sv
tb/sv/set_assoc_cache_directory_tb.sv
